// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on a rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every enabled edge
`define CHK_ALWAYS(lbl, ck, rstn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (prop)) \
		else $error("assertion failed");

// antecedent at one edge implies consequent at the next
`define CHK_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Types and codes shared by the buddy block allocator and its checker.
// ----------------------------------------------------------------------------
package bba_pkg;

	// response status codes
	localparam logic [1:0] STAT_ALLOC = 2'd0;
	localparam logic [1:0] STAT_NOFIT = 2'd1;
	localparam logic [1:0] STAT_FREED = 2'd2;

	// sequencer states
	typedef enum logic [3:0] {
		S_IDLE,
		S_A_SIZE,
		S_A_WALK,
		S_A_CHK,
		S_SPLIT,
		S_F_LOOK,
		S_F_ORD,
		S_F_MERGE,
		S_F_FIND,
		S_F_CHK,
		S_F_PUSH,
		S_DONE
	} state_t;

endpackage

// ===== sv/buddy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator: free blocks kept in one singly linked list in RAM.
// ----------------------------------------------------------------------------
// One request at a time. An allocate sizes the request by stepping the order
// up until the block holds it, then walks the free list (one RAM read and one
// check per entry visited), splits once per order above the wanted one and
// finishes. A free reads the block's stored order (the block index is the
// offset minus the header, shifted right by log2 of the minimum block size,
// which must be a power of two), then per merge attempt walks the list until
// the buddy is found, and pushes the block. The list walk, paced by the
// registered RAM read, sets the rate.
// A finished response is held in an output register; the next request is
// accepted while it waits. No clearing pass is needed after reset.
module buddy_block_allocator import bba_pkg::*; #(
	parameter int POOL_BYTES      = 65536,
	parameter int MIN_BLOCK_BYTES = 32,
	parameter int HEADER_BYTES    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        cmd,
	input  logic [16:0] request_size,
	input  logic [15:0] release_offset,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [15:0] payload_offset
);

	localparam int NBLK       = POOL_BYTES / MIN_BLOCK_BYTES;
	localparam int AW         = $clog2(NBLK);
	localparam int IW         = $clog2(NBLK + 1);
	localparam int HW         = IW + 1;
	localparam int SW         = $clog2(NBLK + 2);
	localparam int POOL_ORDER = $clog2((POOL_BYTES + MIN_BLOCK_BYTES - 1) / MIN_BLOCK_BYTES);
	localparam int OW         = $clog2(POOL_ORDER + 1);
	localparam int OW1        = $clog2(POOL_ORDER + 2);
	localparam int SZW        = $clog2(MIN_BLOCK_BYTES) + POOL_ORDER + 2;
	localparam int CMPW       = (SZW > 18) ? SZW : 18;
	localparam int MW         = $clog2(MIN_BLOCK_BYTES);

	state_t state_q, state_d;

	// request and walk registers
	logic [CMPW-1:0] need_q;
	logic [OW1-1:0]  want_q;
	logic [IW-1:0]   cur_q, pred_q, idx_q, buddy_q, head_q;
	logic [SW-1:0]   steps_q;
	logic [OW-1:0]   ord_q;
	logic [15:0]     quo_q;
	logic            so0_q, nl0_q;
	logic [AW-1:0]   ra_q;
	logic [1:0]      res_status_q;
	logic [15:0]     res_off_q;
	logic            rsp_valid_q;
	logic [1:0]      status_q;
	logic [15:0]     offset_q;

	// RAM ports
	logic            so_we, nl_we, rd_en;
	logic [AW-1:0]   so_wa, nl_wa, rd_addr;
	logic [OW-1:0]   so_wd, so_rd;
	logic [IW-1:0]   nl_wd, nl_rd;

	// derived values
	logic [OW-1:0]   so_dat, so_cl;
	logic [IW-1:0]   nl_dat, buddy_c;
	logic [CMPW-1:0] blk_sz;
	logic [HW-1:0]   half;
	logic            half_ok, walk_end, found, pred_nil, unlink;
	logic [31:0]     grant;

	bba_ram #(.WIDTH(OW), .DEPTH(NBLK)) u_so_ram (
		.clk(clk), .we(so_we), .waddr(so_wa), .wdata(so_wd),
		.re(rd_en), .raddr(rd_addr), .rdata(so_rd)
	);

	bba_ram #(.WIDTH(IW), .DEPTH(NBLK)) u_nl_ram (
		.clk(clk), .we(nl_we), .waddr(nl_wa), .wdata(nl_wd),
		.re(rd_en), .raddr(rd_addr), .rdata(nl_rd)
	);

	// entry 0 reads as the whole free pool until first written
	assign so_dat = (ra_q == '0 && !so0_q) ? OW'(POOL_ORDER) : so_rd;
	assign nl_dat = (ra_q == '0 && !nl0_q) ? IW'(NBLK) : nl_rd;
	assign so_cl  = (so_dat > OW'(POOL_ORDER)) ? OW'(POOL_ORDER) : so_dat;

	// misc datapath
	assign blk_sz   = CMPW'(MIN_BLOCK_BYTES) << want_q;
	assign buddy_c  = idx_q ^ (IW'(1) << ord_q);
	assign half     = HW'(cur_q) + (HW'(1) << (ord_q - OW'(1)));
	assign half_ok  = half < HW'(NBLK);
	assign walk_end = (steps_q > SW'(NBLK)) || (cur_q >= IW'(NBLK));
	assign found    = {1'b0, so_cl} >= {1'b0, want_q};
	assign pred_nil = pred_q == IW'(NBLK);
	assign unlink   = (cur_q == buddy_q) && (so_dat == ord_q);
	assign grant    = 32'(cur_q) * 32'(MIN_BLOCK_BYTES) + 32'(HEADER_BYTES);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					if (!cmd) state_d = S_A_SIZE;
					else if (release_offset < 16'(HEADER_BYTES)) state_d = S_DONE;
					else state_d = S_F_LOOK;
				end
			end
			S_A_SIZE: begin
				if (want_q > OW1'(POOL_ORDER)) state_d = S_DONE;
				else if (blk_sz >= need_q) state_d = S_A_WALK;
			end
			S_A_WALK:  state_d = walk_end ? S_DONE : S_A_CHK;
			S_A_CHK:   state_d = found ? S_SPLIT : S_A_WALK;
			S_SPLIT:   state_d = ({1'b0, ord_q} > {1'b0, want_q}) ? S_SPLIT : S_DONE;
			S_F_LOOK:  state_d = (32'(quo_q) >= 32'(NBLK)) ? S_DONE : S_F_ORD;
			S_F_ORD:   state_d = S_F_MERGE;
			S_F_MERGE: begin
				if (ord_q >= OW'(POOL_ORDER) || buddy_c >= IW'(NBLK)) state_d = S_F_PUSH;
				else state_d = S_F_FIND;
			end
			S_F_FIND:  state_d = walk_end ? S_F_PUSH : S_F_CHK;
			S_F_CHK: begin
				if (cur_q == buddy_q) state_d = unlink ? S_F_MERGE : S_F_PUSH;
				else state_d = S_F_FIND;
			end
			S_F_PUSH:  state_d = S_DONE;
			S_DONE:    state_d = (!rsp_valid_q || !rsp_stall) ? S_IDLE : S_DONE;
			default:   state_d = S_IDLE;
		endcase
	end

	// RAM control
	always_comb begin
		so_we   = 1'b0;
		so_wa   = AW'(cur_q);
		so_wd   = ord_q;
		nl_we   = 1'b0;
		nl_wa   = AW'(pred_q);
		nl_wd   = nl_dat;
		rd_en   = 1'b0;
		rd_addr = AW'(cur_q);
		case (state_q)
			S_A_WALK, S_F_FIND: begin
				rd_en = !walk_end;
			end
			S_F_LOOK: begin
				rd_en   = 32'(quo_q) < 32'(NBLK);
				rd_addr = AW'(quo_q);
			end
			S_A_CHK: begin
				nl_we = found && !pred_nil;
			end
			S_F_CHK: begin
				nl_we = unlink && !pred_nil;
			end
			S_SPLIT: begin
				if ({1'b0, ord_q} > {1'b0, want_q}) begin
					so_we = half_ok;
					so_wa = AW'(half);
					so_wd = ord_q - OW'(1);
					nl_we = half_ok;
					nl_wa = AW'(half);
					nl_wd = head_q;
				end else begin
					so_we = 1'b1;
					so_wd = OW'(want_q);
				end
			end
			S_F_PUSH: begin
				so_we = 1'b1;
				so_wa = AW'(idx_q);
				nl_we = 1'b1;
				nl_wa = AW'(idx_q);
				nl_wd = head_q;
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			so0_q       <= 1'b0;
			nl0_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (so_we && so_wa == '0) so0_q <= 1'b1;
			if (nl_we && nl_wa == '0) nl0_q <= 1'b1;
			// list head updates
			case (state_q)
				S_A_CHK: if (found && pred_nil) head_q <= nl_dat;
				S_F_CHK: if (unlink && pred_nil) head_q <= nl_dat;
				S_SPLIT: begin
					if ({1'b0, ord_q} > {1'b0, want_q} && half_ok) head_q <= IW'(half);
				end
				S_F_PUSH: head_q <= idx_q;
				default: begin
				end
			endcase
			// output register
			if (state_q == S_DONE && (!rsp_valid_q || !rsp_stall)) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (rd_en) ra_q <= rd_addr;
		case (state_q)
			S_IDLE: begin
				need_q       <= CMPW'(request_size) + CMPW'(HEADER_BYTES);
				want_q       <= '0;
				cur_q        <= head_q;
				pred_q       <= IW'(NBLK);
				steps_q      <= '0;
				// block index of the released payload
				quo_q        <= 16'((release_offset - 16'(HEADER_BYTES)) >> MW);
				res_status_q <= cmd ? STAT_FREED : STAT_NOFIT;
				res_off_q    <= '0;
			end
			S_A_SIZE: begin
				if (blk_sz < need_q) want_q <= want_q + OW1'(1);
			end
			S_A_CHK, S_F_CHK: begin
				if (state_q == S_A_CHK && found) begin
					ord_q <= so_cl;
				end else if (state_q == S_F_CHK && unlink) begin
					if (buddy_q < idx_q) idx_q <= buddy_q;
					ord_q <= ord_q + OW'(1);
				end else begin
					pred_q  <= cur_q;
					cur_q   <= nl_dat;
					steps_q <= steps_q + SW'(1);
				end
			end
			S_SPLIT: begin
				if ({1'b0, ord_q} > {1'b0, want_q}) begin
					ord_q <= ord_q - OW'(1);
				end else begin
					res_status_q <= STAT_ALLOC;
					res_off_q    <= grant[15:0];
				end
			end
			S_F_LOOK: idx_q <= IW'(quo_q);
			S_F_ORD:  ord_q <= so_cl;
			S_F_MERGE: begin
				buddy_q <= buddy_c;
				cur_q   <= head_q;
				pred_q  <= IW'(NBLK);
				steps_q <= '0;
			end
			S_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					status_q <= res_status_q;
					offset_q <= res_off_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign req_stall      = state_q != S_IDLE;
	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign payload_offset = offset_q;

endmodule

// ===== sv/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/bba_checker.sv =====
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the buddy block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bba_checker import bba_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_stall,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [1:0]  status,
	input logic [15:0] payload_offset
);

	// a held response keeps its contents
	`CHK_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(status) && $stable(payload_offset))

	// only defined status codes are reported
	`CHK_ALWAYS(a_status_code, clk, arst_n, !rsp_valid || status != 2'd3)

	// failed allocations and frees carry no offset
	`CHK_ALWAYS(a_offset_zero, clk, arst_n, !rsp_valid || status == STAT_ALLOC || payload_offset == 16'd0)

	// an accepted request keeps the block busy in the next cycle
	`CHK_NEXT(a_busy_after, clk, arst_n, req_valid && !req_stall, req_stall)

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);
